### rtl/core/hrpi_pkg.sv
// Package for the Hall rotor phase interpolator.
// Holds the payload structs, fixed field widths, constants, controller states and
// the command and status structs. It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hrpi_pkg;

  localparam int unsigned NUM_SECTORS = 8;
  localparam int unsigned SECTOR_W    = 3;
  localparam int unsigned OFFSET_W    = 9;
  localparam int unsigned SPAN_W      = 9;
  localparam int unsigned ENTRY_W     = 18;
  localparam int unsigned PHASE_W     = 10;
  localparam int unsigned TICKS_W     = 8;
  localparam int unsigned HIST_W      = 4;
  localparam int unsigned DIFF_W      = 12;

  localparam logic [HIST_W-1:0]   EDGE_RISE      = 4'h3;
  localparam logic [HIST_W-1:0]   EDGE_FALL      = 4'hE;
  localparam logic [OFFSET_W-1:0] INVALID_OFFSET = 9'd255;
  localparam logic [ENTRY_W-1:0]  ENTRY_RESET    = 18'd255;
  localparam logic [PHASE_W-1:0]  PHASE_MAX      = 10'd1023;
  localparam logic [PHASE_W:0]    RISE_STEP      = 11'd5;

  localparam logic signed [DIFF_W-1:0] WRAP_LIMIT = 12'sd300;
  localparam logic signed [DIFF_W-1:0] FULL_TURN  = 12'sd360;
  localparam logic signed [DIFF_W-1:0] MAX_RISE   = 12'sd5;

  typedef struct packed {
    logic               hall_a;
    logic               hall_b;
    logic               hall_c;
    logic [TICKS_W-1:0] elapsed_ticks;
  } hall_in_t;

  typedef struct packed {
    logic [PHASE_W-1:0]  rotor_phase;
    logic [PHASE_W-1:0]  limited_phase;
    logic [SECTOR_W-1:0] active_sector;
    logic                block_mode;
  } hall_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic sample;
    logic eval;
    logic load;
    logic mul;
    logic div;
    logic fin;
  } hrpi_cmd_t;

  typedef struct packed {
    logic bare;
    logic div_last;
    logic out_blocked;
  } hrpi_status_t;

endpackage

`default_nettype wire

### rtl/core/hrpi_ctrl.sv
// Controller state machine for the Hall rotor phase interpolator.
// Sequences one request through the datapath; depends on hrpi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hrpi_ctrl
  import hrpi_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire hrpi_status_t status_i,
  output hrpi_cmd_t         cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.sample = 1'b1;
          state_d      = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        if (status_i.bare) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.mul = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!status_i.out_blocked) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && status_i.div_last) |=> state_q == ST_FIN)
    else $error("divider did not hand over to the finish step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.fin || cmd_o.div) |-> !cmd_o.sample)
    else $error("new request taken while one is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> state_q == ST_IDLE)
    else $error("input open while a request is in flight");

endmodule

`default_nettype wire

### rtl/core/hrpi_datapath.sv
// Datapath for the Hall rotor phase interpolator: edge detection, sector table,
// timer, duration store, serial divider, rate limiter and output register.
// Depends on hrpi_pkg and is driven by hrpi_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module hrpi_datapath
  import hrpi_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire hrpi_cmd_t             cmd_i,
  output hrpi_status_t               status_o,
  input  wire hall_in_t              in_data_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [SECTOR_W-1:0]   cfg_index_i,
  input  wire logic [ENTRY_W-1:0]    cfg_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output hall_out_t                  out_data_o
);

  localparam int unsigned PROD_W = TIMER_BITS + SPAN_W;
  localparam int unsigned CNT_W  = $clog2(PROD_W);

  logic [ENTRY_W-1:0]    entry_q [NUM_SECTORS];
  logic [TIMER_BITS-1:0] dur_q [NUM_SECTORS];
  logic [HIST_W-1:0]     hist_a_q, hist_b_q, hist_c_q;
  logic                  lock_a_q, lock_b_q, lock_c_q;
  logic [SECTOR_W-1:0]   now_sec_q, before_q, src_q;
  logic [TIMER_BITS-1:0] timer_q, now_t_q;
  logic                  wrapped_q, block_q;
  logic [PHASE_W-1:0]    last_q;
  logic [OFFSET_W-1:0]   offset_q;
  logic [SPAN_W-1:0]     span_q;
  logic [TIMER_BITS-1:0] div_q;
  logic                  bare_q;
  logic [PROD_W-1:0]     quo_q;
  logic [TIMER_BITS-1:0] rem_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  out_valid_q;
  hall_out_t             out_data_q;

  logic [HIST_W-1:0]     ha_d, hb_d, hc_d;
  logic                  la_d, lb_d, lc_d, edge_seen;
  logic [TIMER_BITS:0]   tsum;
  logic [SECTOR_W-1:0]   rd_sec;
  logic [SECTOR_W-1:0]   dur_sec;
  logic [ENTRY_W-1:0]    entry_rd;
  logic [TIMER_BITS-1:0] dur_rd;
  logic                  sec_valid;
  logic [TIMER_BITS:0]   trial;
  logic                  trial_ge;
  logic [SPAN_W-1:0]     q_clamped;
  logic [PHASE_W-1:0]    phase;
  logic signed [DIFF_W-1:0] diff_raw, diff;
  logic [PHASE_W:0]      rise_sum;
  logic [PHASE_W-1:0]    limited;

  always_comb begin
    ha_d = {hist_a_q[HIST_W-2:0], in_data_i.hall_a};
    hb_d = {hist_b_q[HIST_W-2:0], in_data_i.hall_b};
    hc_d = {hist_c_q[HIST_W-2:0], in_data_i.hall_c};
    la_d = lock_a_q;
    lb_d = lock_b_q;
    lc_d = lock_c_q;
    edge_seen = 1'b0;
    if ((ha_d == EDGE_RISE || ha_d == EDGE_FALL) && !la_d) begin
      la_d = 1'b1; lb_d = 1'b0; lc_d = 1'b0; edge_seen = 1'b1;
    end
    if ((hb_d == EDGE_RISE || hb_d == EDGE_FALL) && !lb_d) begin
      la_d = 1'b0; lb_d = 1'b1; lc_d = 1'b0; edge_seen = 1'b1;
    end
    if ((hc_d == EDGE_RISE || hc_d == EDGE_FALL) && !lc_d) begin
      la_d = 1'b0; lb_d = 1'b0; lc_d = 1'b1; edge_seen = 1'b1;
    end
  end

  assign tsum      = {1'b0, timer_q} + (TIMER_BITS+1)'(in_data_i.elapsed_ticks);
  assign rd_sec    = cmd_i.eval ? now_sec_q : src_q;
  assign dur_sec   = cmd_i.eval ? before_q : src_q;
  assign entry_rd  = entry_q[rd_sec];
  assign dur_rd    = dur_q[dur_sec];
  assign sec_valid = entry_rd[OFFSET_W-1:0] != INVALID_OFFSET;

  assign trial    = {rem_q, quo_q[PROD_W-1]};
  assign trial_ge = trial >= {1'b0, div_q};

  always_comb begin
    if (quo_q > PROD_W'(span_q)) begin
      q_clamped = span_q;
    end else begin
      q_clamped = quo_q[SPAN_W-1:0];
    end
    if (bare_q) begin
      phase = PHASE_W'(offset_q);
    end else begin
      phase = PHASE_W'(offset_q) + PHASE_W'(q_clamped);
    end
    diff_raw = $signed({2'b00, phase}) - $signed({2'b00, last_q});
    if (diff_raw < -WRAP_LIMIT) begin
      diff = diff_raw + FULL_TURN;
    end else if (diff_raw > WRAP_LIMIT) begin
      diff = diff_raw - FULL_TURN;
    end else begin
      diff = diff_raw;
    end
    rise_sum = {1'b0, last_q} + RISE_STEP;
    if (diff > MAX_RISE) begin
      limited = rise_sum[PHASE_W] ? PHASE_MAX : rise_sum[PHASE_W-1:0];
    end else begin
      limited = phase;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SECTORS; i++) begin
        entry_q[i] <= ENTRY_RESET;
        dur_q[i]   <= '0;
      end
      hist_a_q    <= '0;
      hist_b_q    <= '0;
      hist_c_q    <= '0;
      lock_a_q    <= 1'b0;
      lock_b_q    <= 1'b0;
      lock_c_q    <= 1'b0;
      now_sec_q   <= '0;
      before_q    <= '0;
      src_q       <= '0;
      timer_q     <= '0;
      now_t_q     <= '0;
      wrapped_q   <= 1'b0;
      block_q     <= 1'b1;
      last_q      <= '0;
      bare_q      <= 1'b1;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        entry_q[cfg_index_i] <= cfg_data_i;
      end
      if (cmd_i.sample) begin
        hist_a_q  <= ha_d;
        hist_b_q  <= hb_d;
        hist_c_q  <= hc_d;
        lock_a_q  <= la_d;
        lock_b_q  <= lb_d;
        lock_c_q  <= lc_d;
        if (edge_seen) begin
          now_sec_q <= {in_data_i.hall_c, in_data_i.hall_b, in_data_i.hall_a};
        end
        if (tsum[TIMER_BITS]) begin
          wrapped_q <= 1'b1;
        end
        timer_q <= tsum[TIMER_BITS-1:0];
        now_t_q <= tsum[TIMER_BITS-1:0];
      end
      if (cmd_i.eval) begin
        if (sec_valid) begin
          src_q    <= now_sec_q;
          before_q <= now_sec_q;
          if (now_sec_q != before_q) begin
            timer_q <= '0;
            if (wrapped_q) begin
              wrapped_q <= 1'b0;
              block_q   <= 1'b1;
            end else if (now_t_q >= (dur_rd >> 1)) begin
              dur_q[before_q] <= now_t_q;
              block_q         <= 1'b0;
            end
          end
        end else begin
          src_q <= before_q;
        end
      end
      if (cmd_i.load) begin
        bare_q <= block_q || (dur_rd == '0);
      end
      if (cmd_i.mul) begin
        cnt_q <= '0;
      end else if (cmd_i.div) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
        last_q      <= phase;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      offset_q <= entry_rd[OFFSET_W-1:0];
      span_q   <= entry_rd[ENTRY_W-1:OFFSET_W];
      div_q    <= dur_rd;
    end
    if (cmd_i.mul) begin
      quo_q <= PROD_W'(now_t_q) * PROD_W'(span_q);
      rem_q <= '0;
    end else if (cmd_i.div) begin
      quo_q <= {quo_q[PROD_W-2:0], trial_ge};
      if (trial_ge) begin
        rem_q <= TIMER_BITS'(trial - {1'b0, div_q});
      end else begin
        rem_q <= trial[TIMER_BITS-1:0];
      end
    end
    if (cmd_i.fin) begin
      out_data_q.rotor_phase   <= phase;
      out_data_q.limited_phase <= limited;
      out_data_q.active_sector <= now_sec_q;
      out_data_q.block_mode    <= bare_q;
    end
  end

  assign status_o.bare        = bare_q;
  assign status_o.div_last    = cnt_q == CNT_W'(PROD_W - 1);
  assign status_o.out_blocked = out_valid_q && out_stall_i;
  assign out_valid_o          = out_valid_q;
  assign out_data_o           = out_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin |=> out_valid_q && out_data_q.rotor_phase == last_q)
    else $error("result register and phase history disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div |-> div_q != '0)
    else $error("division started with a zero sector time");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin |-> !(out_valid_q && out_stall_i))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

### rtl/core/hall_rotor_phase_interpolator_unit.sv
// Top level: an interpolating request runs through sample, evaluate, load, multiply,
// TIMER_BITS + 9 divider steps (one per quotient bit) and finish; when the phase is the
// bare sector offset, the multiply and divider steps are skipped. One request is in flight
// at a time, so a new request is taken only once the last one has finished; a result still waiting on
// a stalled receiver holds the finish step. Depends on hrpi_ctrl and hrpi_datapath.
// Reset: control and timing state clear, sector entries return to 255 and block mode is set.
`timescale 1ns / 1ps
`default_nettype none

module hall_rotor_phase_interpolator_unit
  import hrpi_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire hall_in_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output hall_out_t                out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [SECTOR_W-1:0] cfg_index_i,
  input  wire logic [ENTRY_W-1:0]  cfg_data_i
);

  hrpi_cmd_t    cmd;
  hrpi_status_t status;

  hrpi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hrpi_datapath #(
    .TIMER_BITS (TIMER_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
